/* rtl/core/fpp_pkg.sv */
// Shared types and constants for the farthest point pair block.
package fpp_pkg;

  localparam int DIST_BITS = 50;
  localparam logic [DIST_BITS-1:0] DIST_LIM = {DIST_BITS{1'b1}};

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_S_RD,
    ST_S_KEY,
    ST_S_CMP,
    ST_H_RD,
    ST_H_CUR,
    ST_H_CHK,
    ST_H_CRD,
    ST_H_PA,
    ST_H_MUL,
    ST_H_DEC,
    ST_W_CHK,
    ST_W_U,
    ST_W_UA,
    ST_W_LB,
    ST_W_SQ,
    ST_W_SUM,
    ST_W_N,
    ST_W_NU,
    ST_W_NL,
    ST_W_CR,
    ST_W_ADV,
    ST_OUT
  } state_t;

endpackage

/* rtl/core/fpp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/farthest_point_pair.sv */
// Farthest point pair: loads a point set, then sorts, builds hulls and walks calipers.
// Loading takes one cycle per point; the final point starts the computation.
// Sort is an in-place insertion sort.
// Hull build, once per chain: each point gets a turn test once the chain holds two
// entries, and every pop repeats it; calipers advance one chain per step.
// One result per set, held until taken; no new point is accepted meanwhile.
// Reset clears the state machine, point count and drop flag; memories are not cleared.
module farthest_point_pair import fpp_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  last_point,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIST_BITS-1:0]  max_sq_distance,
  output logic                  overflow
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = AW + 1;
  localparam int PTW = 2 * COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int XW  = PW + DIST_BITS;

  function automatic logic signed [DW-1:0] px(input logic [PTW-1:0] p);
    px = $signed({p[PTW-1], p[PTW-1:COORD_BITS]});
  endfunction

  function automatic logic signed [DW-1:0] py(input logic [PTW-1:0] p);
    py = $signed({p[COORD_BITS-1], p[COORD_BITS-1:0]});
  endfunction

  function automatic logic pt_less(input logic [PTW-1:0] p, input logic [PTW-1:0] q);
    pt_less = (px(p) == px(q)) ? (py(p) < py(q)) : (px(p) < px(q));
  endfunction

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic dropped, dropped_next;
  logic [CW-1:0] n, n_next, i, i_next, j, j_next, top, top_next, nu, nu_next;
  logic [CW-1:0] ca, ca_next, cb, cb_next;
  logic lower_ph, lower_ph_next;
  logic [PTW-1:0] key, key_next, pa, pa_next, pb, pb_next, pc, pc_next, pd, pd_next;
  logic [AW-1:0] lidx, lidx_next;
  logic signed [PW-1:0] prod_l, prod_l_next, prod_r, prod_r_next;
  logic [DIST_BITS-1:0] best, best_next;

  logic s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [PTW-1:0] s_wdata, s_rdata;
  logic cu_we, cl_we;
  logic [AW-1:0] c_waddr, cu_raddr, cl_raddr;
  logic [AW-1:0] c_wdata, cu_rdata, cl_rdata;

  fpp_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  fpp_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_upper (
    .clk(clk), .we(cu_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(cu_raddr), .rdata(cu_rdata)
  );

  fpp_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_lower (
    .clk(clk), .we(cl_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(cl_raddr), .rdata(cl_rdata)
  );

  // operand differences for the turn test, the distance and the caliper test
  logic signed [DW-1:0] ux, uy, vx, vy, dx, dy, dux, duy, dlx, dly;
  assign ux  = px(pb) - px(pa);
  assign uy  = py(pb) - py(pa);
  assign vx  = px(pc) - px(pb);
  assign vy  = py(pc) - py(pb);
  assign dx  = px(pa) - px(pb);
  assign dy  = py(pa) - py(pb);
  assign dux = px(pc) - px(pa);
  assign duy = py(pc) - py(pa);
  assign dlx = px(pd) - px(pb);
  assign dly = py(pd) - py(pb);

  logic [CW-1:0] cur_pos;
  logic [AW-1:0] cur_idx;
  assign cur_pos = lower_ph ? (n - CW'(1) - i) : i;
  assign cur_idx = cur_pos[AW-1:0];

  logic [PW-1:0] sq_sum;
  logic [XW-1:0] sum_w;
  logic [DIST_BITS-1:0] sat_dist;
  assign sq_sum   = $unsigned(prod_l) + $unsigned(prod_r);
  assign sum_w    = XW'(sq_sum);
  assign sat_dist = (sum_w > XW'(DIST_LIM)) ? DIST_LIM : sum_w[DIST_BITS-1:0];

  assign in_stall        = (state != ST_LOAD);
  assign out_valid       = (state == ST_OUT);
  assign max_sq_distance = best;
  assign overflow        = dropped;

  always_comb begin
    logic push;
    push          = 1'b0;
    state_next    = state;
    count_next    = count;
    dropped_next  = dropped;
    n_next        = n;
    i_next        = i;
    j_next        = j;
    top_next      = top;
    nu_next       = nu;
    ca_next       = ca;
    cb_next       = cb;
    lower_ph_next = lower_ph;
    key_next      = key;
    pa_next       = pa;
    pb_next       = pb;
    pc_next       = pc;
    pd_next       = pd;
    lidx_next     = lidx;
    prod_l_next   = prod_l;
    prod_r_next   = prod_r;
    best_next     = best;
    s_we          = 1'b0;
    s_waddr       = count[AW-1:0];
    s_wdata       = {point_x, point_y};
    s_raddr       = i[AW-1:0];
    cu_we         = 1'b0;
    cl_we         = 1'b0;
    c_waddr       = top[AW-1:0];
    c_wdata       = cur_idx;
    cu_raddr      = ca[AW-1:0];
    cl_raddr      = cb[AW-1:0];

    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          if (count < CW'(MAX_POINTS)) begin
            s_we       = 1'b1;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (last_point) begin
            n_next     = count_next;
            i_next     = CW'(1);
            state_next = ST_S_RD;
          end
        end
      end
      ST_S_RD: begin
        if (i >= n) begin
          lower_ph_next = 1'b0;
          i_next        = '0;
          top_next      = '0;
          state_next    = ST_H_RD;
        end else begin
          s_raddr    = i[AW-1:0];
          state_next = ST_S_KEY;
        end
      end
      ST_S_KEY: begin
        key_next   = s_rdata;
        j_next     = i;
        s_raddr    = AW'(i - CW'(1));
        state_next = ST_S_CMP;
      end
      ST_S_CMP: begin
        s_we    = 1'b1;
        s_waddr = j[AW-1:0];
        if ((j != '0) && pt_less(key, s_rdata)) begin
          // shift the larger point up and look one further down
          s_wdata = s_rdata;
          j_next  = j - CW'(1);
          s_raddr = AW'(j - CW'(2));
        end else begin
          s_wdata    = key;
          i_next     = i + CW'(1);
          state_next = ST_S_RD;
        end
      end
      ST_H_RD: begin
        if (i >= n) begin
          if (!lower_ph) begin
            nu_next       = top;
            lower_ph_next = 1'b1;
            i_next        = '0;
            top_next      = '0;
          end else begin
            ca_next    = '0;
            cb_next    = '0;
            best_next  = '0;
            state_next = ST_W_CHK;
          end
        end else begin
          s_raddr    = cur_idx;
          state_next = ST_H_CUR;
        end
      end
      ST_H_CUR: begin
        pc_next    = s_rdata;
        state_next = ST_H_CHK;
      end
      ST_H_CHK: begin
        if (top >= CW'(2)) begin
          cu_raddr   = AW'(top - CW'(2));
          cl_raddr   = AW'(top - CW'(2));
          state_next = ST_H_CRD;
        end else begin
          push = 1'b1;
        end
      end
      ST_H_CRD: begin
        s_raddr    = lower_ph ? cl_rdata : cu_rdata;
        state_next = ST_H_PA;
      end
      ST_H_PA: begin
        pa_next    = s_rdata;
        state_next = ST_H_MUL;
      end
      ST_H_MUL: begin
        prod_l_next = ux * vy;
        prod_r_next = uy * vx;
        state_next  = ST_H_DEC;
      end
      ST_H_DEC: begin
        if (prod_l >= prod_r) begin
          // drop the top: left turn or straight
          top_next   = top - CW'(1);
          pb_next    = pa;
          state_next = ST_H_CHK;
        end else begin
          push = 1'b1;
        end
      end
      ST_W_CHK: begin
        if ((ca + CW'(1) < nu) || (cb + CW'(1) < top)) begin
          cu_raddr   = ca[AW-1:0];
          cl_raddr   = cb[AW-1:0];
          state_next = ST_W_U;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_W_U: begin
        s_raddr    = cu_rdata;
        lidx_next  = cl_rdata;
        state_next = ST_W_UA;
      end
      ST_W_UA: begin
        pa_next    = s_rdata;
        s_raddr    = lidx;
        state_next = ST_W_LB;
      end
      ST_W_LB: begin
        pb_next    = s_rdata;
        state_next = ST_W_SQ;
      end
      ST_W_SQ: begin
        prod_l_next = dx * dx;
        prod_r_next = dy * dy;
        state_next  = ST_W_SUM;
      end
      ST_W_SUM: begin
        if (sat_dist > best) begin
          best_next = sat_dist;
        end
        if (ca + CW'(1) == nu) begin
          cb_next    = cb + CW'(1);
          state_next = ST_W_CHK;
        end else if (cb + CW'(1) == top) begin
          ca_next    = ca + CW'(1);
          state_next = ST_W_CHK;
        end else begin
          cu_raddr   = AW'(ca + CW'(1));
          cl_raddr   = AW'(cb + CW'(1));
          state_next = ST_W_N;
        end
      end
      ST_W_N: begin
        s_raddr    = cu_rdata;
        lidx_next  = cl_rdata;
        state_next = ST_W_NU;
      end
      ST_W_NU: begin
        pc_next    = s_rdata;
        s_raddr    = lidx;
        state_next = ST_W_NL;
      end
      ST_W_NL: begin
        pd_next    = s_rdata;
        state_next = ST_W_CR;
      end
      ST_W_CR: begin
        prod_l_next = dux * dly;
        prod_r_next = duy * dlx;
        state_next  = ST_W_ADV;
      end
      ST_W_ADV: begin
        if (prod_l > prod_r) begin
          ca_next = ca + CW'(1);
        end else begin
          cb_next = cb + CW'(1);
        end
        state_next = ST_W_CHK;
      end
      ST_OUT: begin
        if (!out_stall) begin
          count_next   = '0;
          dropped_next = 1'b0;
          state_next   = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase

    if (push) begin
      cu_we      = !lower_ph;
      cl_we      = lower_ph;
      c_waddr    = top[AW-1:0];
      c_wdata    = cur_idx;
      top_next   = top + CW'(1);
      pb_next    = pc;
      i_next     = i + CW'(1);
      state_next = ST_H_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    n        <= n_next;
    i        <= i_next;
    j        <= j_next;
    top      <= top_next;
    nu       <= nu_next;
    ca       <= ca_next;
    cb       <= cb_next;
    lower_ph <= lower_ph_next;
    key      <= key_next;
    pa       <= pa_next;
    pb       <= pb_next;
    pc       <= pc_next;
    pd       <= pd_next;
    lidx     <= lidx_next;
    prod_l   <= prod_l_next;
    prod_r   <= prod_r_next;
    best     <= best_next;
  end

endmodule

/* sim/tb_farthest_point_pair.sv */
// Testbench for the farthest point pair block: directed and random point sets.
module tb_farthest_point_pair;
  import fpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 1024;
  localparam int CB = 24;
  localparam int WATCH_LIMIT = 2000000;

  typedef struct {
    logic [DIST_BITS-1:0] sq_dist;
    logic                 ovf;
  } diam_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, last_point = 0, out_stall = 0;
  logic [CB-1:0] point_x = '0, point_y = '0;
  logic in_stall, out_valid, overflow;
  logic [DIST_BITS-1:0] max_sq_distance;

  farthest_point_pair #(.MAX_POINTS(MAXP), .COORD_BITS(CB)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the block's point set
  longint set_x[$], set_y[$];
  bit set_dropped;
  diam_t diam_q[$];
  int errors = 0, sets_done = 0, points_sent = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_recv = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    longint l, r;
    l = (bx - ax) * (cy - by);
    r = (by - ay) * (cx - bx);
    return l < r ? -1 : (l > r ? 1 : 0);
  endfunction

  function automatic logic [DIST_BITS-1:0] hull_diameter();
    longint xs[$], ys[$], tx, ty, dx, dy, d, best;
    int up[$], lo[$];
    int n, j, a, b;
    xs = set_x;
    ys = set_y;
    n = xs.size();
    best = 0;
    if (n == 0) return 0;
    for (int i = 1; i < n; i++) begin
      tx = xs[i];
      ty = ys[i];
      j = i;
      while (j > 0 && (tx == xs[j-1] ? ty < ys[j-1] : tx < xs[j-1])) begin
        xs[j] = xs[j-1];
        ys[j] = ys[j-1];
        j--;
      end
      xs[j] = tx;
      ys[j] = ty;
    end
    for (int k = 0; k < n; k++) begin
      j = n - 1 - k;
      while (up.size() >= 2 && turn_sign(xs[up[$-1]], ys[up[$-1]], xs[up[$]], ys[up[$]],
                                         xs[k], ys[k]) >= 0) void'(up.pop_back());
      while (lo.size() >= 2 && turn_sign(xs[lo[$-1]], ys[lo[$-1]], xs[lo[$]], ys[lo[$]],
                                         xs[j], ys[j]) >= 0) void'(lo.pop_back());
      up.push_back(k);
      lo.push_back(j);
    end
    a = 0;
    b = 0;
    while (a + 1 < up.size() || b + 1 < lo.size()) begin
      dx = xs[up[a]] - xs[lo[b]];
      dy = ys[up[a]] - ys[lo[b]];
      d = dx * dx + dy * dy;
      if (d > best) best = d;
      if (a + 1 == up.size()) b++;
      else if (b + 1 == lo.size()) a++;
      else if ((xs[up[a+1]] - xs[up[a]]) * (ys[lo[b+1]] - ys[lo[b]]) >
               (ys[up[a+1]] - ys[up[a]]) * (xs[lo[b+1]] - xs[lo[b]])) a++;
      else b++;
    end
    return best[DIST_BITS-1:0];
  endfunction

  // leave valid up after the transaction; an idle cycle in the next call or drain() drops it
  task automatic send_point(input longint x, input longint y, input bit fin);
    diam_t e;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      if (in_valid) in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    point_x <= x[CB-1:0];
    point_y <= y[CB-1:0];
    last_point <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    if (set_x.size() < MAXP) begin
      set_x.push_back($signed(x[CB-1:0]));
      set_y.push_back($signed(y[CB-1:0]));
    end else set_dropped = 1;
    if (fin) begin
      e.sq_dist = hull_diameter();
      e.ovf = set_dropped;
      diam_q.push_back(e);
      set_x.delete();
      set_y.delete();
      set_dropped = 0;
    end
  endtask

  function automatic longint rand_coord(input int span);
    if (span >= CB) return $signed(24'($urandom));
    return longint'($urandom_range((1 << span) - 1)) - (1 << (span - 1));
  endfunction

  task automatic send_set(input int n, input int span);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(span), rand_coord(span), i == n - 1);
  endtask

  // receiver: stall pattern and the long hold-off
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= hold_recv || (recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    diam_t e;
    if (!rst && out_valid && !out_stall) begin
      if (diam_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        e = diam_q.pop_front();
        sets_done++;
        if (max_sq_distance !== e.sq_dist)
          report_mismatch($sformatf("distance %0d, expected %0d", max_sq_distance,
                                    e.sq_dist));
        if (overflow !== e.ovf)
          report_mismatch($sformatf("overflow %0b, expected %0b", overflow, e.ovf));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("Watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 0;
    while (diam_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_point(5, 7, 1);                       // single point
    send_point(-8388608, -8388608, 0);         // widest span
    send_point(8388607, 8388607, 1);
    send_point(-8388608, 8388607, 0);
    send_point(8388607, -8388608, 0);
    send_point(0, 0, 1);
    send_point(3, 3, 0);                       // repeated points
    send_point(3, 3, 0);
    send_point(3, 3, 1);
    for (int i = 0; i < 5; i++) send_point(i, 2 * i, i == 4);  // collinear
    send_point(0, 0, 0);
    send_point(4, 0, 0);
    send_point(4, 4, 0);
    send_point(0, 4, 0);
    send_point(2, 2, 1);
    drain();
  endtask

  task automatic test_overflow();
    send_set(MAXP + 2, 16);
    drain();
  endtask

  task automatic test_random(input int items, input int s_idle, input int r_stall);
    int n, sent;
    send_idle = s_idle;
    recv_stall = r_stall;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      send_set(n, ($urandom_range(3) == 0) ? CB : $urandom_range(3, 12));
      sent += n;
    end
    drain();
    send_idle = 0;
    recv_stall = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (3000) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int i = 0; i < 8; i++) send_set(4, 10);
      end
    join
    drain();
  endtask

  initial begin
    set_dropped = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(150, 0, 0);
    test_random(100, 86, 0);
    test_random(100, 0, 86);
    test_random(100, 38, 38);
    test_backpressure();
    test_random(80, 0, 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d points in %0d sets, including store overflow and stalls",
             points_sent, sets_done);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

/* farthest_point_pair.f */
rtl/core/fpp_pkg.sv
rtl/core/fpp_ram.sv
rtl/core/farthest_point_pair.sv
sim/tb_farthest_point_pair.sv
